### design/srdc_pkg.sv
// Shared types and constants for the stepper ramp and direction controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package srdc_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_FORWARD  = 2'd0;
    localparam logic [1:0] REQ_BACKWARD = 2'd1;
    localparam logic [1:0] REQ_STOP     = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FAST_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_SLOW_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_DELAY_STEP  = 2'd2;
    localparam logic [1:0] CFG_FWD_LEVEL   = 2'd3;

    // Reset values.
    localparam logic [15:0] RST_FAST_LIMIT  = 16'd600;
    localparam logic [15:0] RST_SLOW_LIMIT  = 16'd5000;
    localparam logic [7:0]  RST_DELAY_STEP  = 8'd10;
    localparam logic        RST_FWD_LEVEL   = 1'b1;
    localparam logic [15:0] RST_STEP_DELAY  = 16'd5000;

    typedef struct packed {
        logic [15:0] fast_limit;
        logic [15:0] slow_limit;
        logic [7:0]  delay_step;
        logic        fwd_level;
    } t_cfg;

    typedef struct packed {
        logic [31:0] last_time;
        logic [15:0] step_delay;
        logic        stopped;
        logic        current_dir;
    } t_ramp_state;

endpackage

`default_nettype wire

### design/srdc_cfg_regs.sv
// Configuration register file of the stepper ramp controller.
// Depends on srdc_pkg for the register indexes, reset values and t_cfg.
`default_nettype none

module srdc_cfg_regs
    import srdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr_en,
    input  wire logic [1:0]  i_wr_index,
    input  wire logic [15:0] i_wr_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_limit <= RST_FAST_LIMIT;
            r_cfg.slow_limit <= RST_SLOW_LIMIT;
            r_cfg.delay_step <= RST_DELAY_STEP;
            r_cfg.fwd_level  <= RST_FWD_LEVEL;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_FAST_LIMIT: r_cfg.fast_limit <= i_wr_data;
                CFG_SLOW_LIMIT: r_cfg.slow_limit <= i_wr_data;
                CFG_DELAY_STEP: r_cfg.delay_step <= i_wr_data[7:0];
                CFG_FWD_LEVEL:  r_cfg.fwd_level  <= i_wr_data[0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/srdc_ramp_core.sv
// Combinational next-state logic of the stepper ramp: deceleration, direction
// flip and acceleration for one move request, or the delay reset of a stop request. Depends on srdc_pkg.
`default_nettype none

module srdc_ramp_core
    import srdc_pkg::*;
(
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_now_us,
    input  wire t_cfg        i_cfg,
    input  wire t_ramp_state i_state,
    output t_ramp_state      o_state,
    output logic             o_step_pulse
);

    logic [31:0] elapsed;
    logic        is_move;
    logic        reverse;
    logic        due_first;
    logic        slow_step;
    logic        slow_stop;
    logic [16:0] grow_sum;
    logic [15:0] delay_mid;
    logic        stopped_mid;
    logic        dir_mid;
    logic        due_second;
    logic        fast_step;
    logic [15:0] delay_fast;

    always_comb begin
        elapsed   = i_now_us - i_state.last_time;
        is_move   = (i_req_type == REQ_FORWARD) || (i_req_type == REQ_BACKWARD);
        // Reversal when the current direction differs from the requested one.
        reverse   = is_move &&
                    ((i_state.current_dir == i_cfg.fwd_level) !=
                     (i_req_type == REQ_FORWARD));
        due_first = elapsed >= {16'd0, i_state.step_delay};
        slow_step = reverse && due_first && (i_state.step_delay < i_cfg.slow_limit);
        slow_stop = reverse && due_first && !(i_state.step_delay < i_cfg.slow_limit);

        grow_sum  = {1'b0, i_state.step_delay} + {9'd0, i_cfg.delay_step};
        delay_mid = slow_step ? (grow_sum[16] ? 16'hFFFF : grow_sum[15:0])
                              : i_state.step_delay;

        stopped_mid = i_state.stopped || slow_stop;
        dir_mid     = (reverse && stopped_mid) ? ~i_state.current_dir
                                               : i_state.current_dir;

        // After a deceleration step the last step time equals now.
        due_second = slow_step ? (delay_mid == 16'd0)
                               : (elapsed >= {16'd0, delay_mid});
        fast_step  = is_move && due_second;

        if (fast_step && (delay_mid > i_cfg.fast_limit)) begin
            delay_fast = (delay_mid > {8'd0, i_cfg.delay_step})
                       ? delay_mid - {8'd0, i_cfg.delay_step} : 16'd0;
        end else begin
            delay_fast = delay_mid;
        end

        o_state = i_state;
        if (is_move) begin
            o_state.step_delay  = delay_fast;
            o_state.stopped     = 1'b0;
            o_state.current_dir = dir_mid;
            if (slow_step || fast_step) begin
                o_state.last_time = i_now_us;
            end
        end else if (i_req_type == REQ_STOP) begin
            o_state.step_delay = i_cfg.slow_limit;
        end
        o_step_pulse = slow_step || fast_step;
    end

endmodule

`default_nettype wire

### design/stepper_ramp_direction_control_top.sv
// Top level of the stepper ramp and direction controller: input register,
// ramp state, result register. Depends on srdc_pkg, srdc_cfg_regs, srdc_ramp_core.
`default_nettype none

// Channel     Handshake                     Payload
// request     i_in_valid / o_in_ready       i_req_type, i_now_us
// result      o_out_valid / i_out_ready     o_step_pulse, o_direction, o_stopped_flag
// config      i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// A request transaction is captured in the input register, evaluated against the
// ramp state by the single ramp stage, and lands in the result register; one
// transaction per cycle is sustained while the result register is not stalled.
// Reset (synchronous, active low) restores the configuration and ramp state.
// When the result register is full and not taken, a held input transaction stays and
// o_in_ready drops; a taken result frees both stages in the same cycle.
// Configuration writes are always accepted.

module stepper_ramp_direction_control_top
    import srdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_now_us,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_step_pulse,
    output logic             o_direction,
    output logic             o_stopped_flag,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg        cfg;
    t_ramp_state r_state;
    t_ramp_state n_state;
    logic        n_pulse;

    // Input register.
    logic        r_in_valid;
    logic [1:0]  r_req_type;
    logic [31:0] r_now_us;

    // Result register.
    logic        r_out_valid;
    logic        r_step_pulse;
    logic        r_direction;
    logic        r_stopped_flag;

    logic        advance;

    assign o_cfg_ready = 1'b1;

    srdc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    srdc_ramp_core u_core (
        .i_req_type   (r_req_type),
        .i_now_us     (r_now_us),
        .i_cfg        (cfg),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_step_pulse (n_pulse)
    );

    // The ramp stage moves when it holds a transaction and the result slot is free
    // or being emptied this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req_type <= i_req_type;
            r_now_us   <= i_now_us;
        end
    end

    // Ramp state is updated once per evaluated transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_time   <= 32'd0;
            r_state.step_delay  <= RST_STEP_DELAY;
            r_state.stopped     <= 1'b1;
            r_state.current_dir <= RST_FWD_LEVEL;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_step_pulse   <= n_pulse;
            r_direction    <= n_state.current_dir;
            r_stopped_flag <= n_state.stopped;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_step_pulse   = r_step_pulse;
    assign o_direction    = r_direction;
    assign o_stopped_flag = r_stopped_flag;

endmodule

`default_nettype wire

### verif/tb_stepper_ramp_direction_control_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for stepper_ramp_direction_control_top.
// Depends on srdc_pkg and the block's RTL; a scoreboard class predicts each result
// from its own ramp state copy; tasks and a receiver loop drive the three channels.

module tb_stepper_ramp_direction_control_top;
    import srdc_pkg::*;

    // The package names three request codes; the fourth must leave the ramp alone.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // One result transaction as seen on the output port.
    typedef struct packed {
        logic step_pulse;
        logic direction;
        logic stopped_flag;
    } t_motion;

    // Ramp predictor and result checker. It keeps its own register set and ramp
    // state, works out the motion for every accepted request and queues it until
    // the matching result transaction comes out.
    class ramp_scoreboard;
        t_cfg          cfg;
        t_ramp_state   ramp;
        t_motion       due[$];
        int unsigned   errors;

        function void restart();
            cfg.fast_limit   = RST_FAST_LIMIT;
            cfg.slow_limit   = RST_SLOW_LIMIT;
            cfg.delay_step   = RST_DELAY_STEP;
            cfg.fwd_level    = RST_FWD_LEVEL;
            ramp.last_time   = '0;
            ramp.step_delay  = RST_STEP_DELAY;
            ramp.stopped     = 1'b1;
            ramp.current_dir = RST_FWD_LEVEL;
            due.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [15:0] data);
            case (index)
                CFG_FAST_LIMIT: cfg.fast_limit = data;
                CFG_SLOW_LIMIT: cfg.slow_limit = data;
                CFG_DELAY_STEP: cfg.delay_step = data[7:0];
                CFG_FWD_LEVEL:  cfg.fwd_level  = data[0];
                default: ;
            endcase
        endfunction

        // Request codes that keep or reverse the present heading.
        function logic [1:0] ahead_request();
            return (ramp.current_dir == cfg.fwd_level) ? REQ_FORWARD : REQ_BACKWARD;
        endfunction

        function logic [1:0] reverse_request();
            return (ramp.current_dir == cfg.fwd_level) ? REQ_BACKWARD : REQ_FORWARD;
        endfunction

        // The time difference wraps with the 32-bit microsecond counter.
        function bit delay_elapsed(logic [31:0] now_us);
            logic [31:0] since;
            since = now_us - ramp.last_time;
            return since >= {16'd0, ramp.step_delay};
        endfunction

        function bit accelerate(logic [31:0] now_us);
            if (!delay_elapsed(now_us))
                return 1'b0;
            // The shrink floors at zero and may overshoot below the minimum.
            if (ramp.step_delay > cfg.fast_limit)
                ramp.step_delay = (ramp.step_delay > {8'd0, cfg.delay_step}) ?
                                  ramp.step_delay - {8'd0, cfg.delay_step} : 16'd0;
            ramp.last_time = now_us;
            return 1'b1;
        endfunction

        function bit decelerate(logic [31:0] now_us);
            logic [16:0] grown;
            if (!delay_elapsed(now_us))
                return 1'b0;
            if (ramp.step_delay < cfg.slow_limit) begin
                grown = {1'b0, ramp.step_delay} + {9'd0, cfg.delay_step};
                ramp.step_delay = grown[16] ? 16'hFFFF : grown[15:0];
                ramp.last_time = now_us;
                return 1'b1;
            end
            // Slowest speed reached: the motor counts as stopped.
            ramp.stopped = 1'b1;
            return 1'b0;
        endfunction

        function bit move(logic [31:0] now_us, bit want_forward);
            bit pulse;
            bit heading_forward;
            pulse = 1'b0;
            heading_forward = (ramp.current_dir == cfg.fwd_level);
            if (heading_forward != want_forward) begin
                pulse = decelerate(now_us);
                // A stopped flag left over from reset also allows the flip.
                if (ramp.stopped)
                    ramp.current_dir = ~ramp.current_dir;
            end
            ramp.stopped = 1'b0;
            pulse = accelerate(now_us) | pulse;
            return pulse;
        endfunction

        function void note_request(logic [1:0] req, logic [31:0] now_us);
            t_motion m;
            m.step_pulse = 1'b0;
            case (req)
                REQ_FORWARD:  m.step_pulse = move(now_us, 1'b1);
                REQ_BACKWARD: m.step_pulse = move(now_us, 1'b0);
                REQ_STOP:     ramp.step_delay = cfg.slow_limit;
                default: ;
            endcase
            m.direction    = ramp.current_dir;
            m.stopped_flag = ramp.stopped;
            due.push_back(m);
        endfunction

        function void compare_field(string field, logic want, logic got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0b, actual %0b",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(t_motion got);
            t_motion want;
            if (due.size() == 0) begin
                errors++;
                $display({"%0t ns: unexpected result, expected none, ",
                          "actual pulse %0b dir %0b stopped %0b"},
                         $time, got.step_pulse, got.direction, got.stopped_flag);
                return;
            end
            want = due.pop_front();
            compare_field("step_pulse", want.step_pulse, got.step_pulse);
            compare_field("direction", want.direction, got.direction);
            compare_field("stopped_flag", want.stopped_flag, got.stopped_flag);
        endfunction
    endclass

    // Every input of the block starts at a known level.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [1:0]  i_req_type  = REQ_STOP;
    logic [31:0] i_now_us    = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_FAST_LIMIT;
    logic [15:0] i_cfg_data  = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_step_pulse;
    logic        o_direction;
    logic        o_stopped_flag;
    logic        o_cfg_ready;

    ramp_scoreboard scoreboard;

    // Number of request transactions taken so far; the receiver uses it to time
    // its long hold-off.
    int unsigned requests_taken = 0;

    // Microsecond time the sender presents with the next request.
    logic [31:0] clock_us = '0;

    // Sender pacing: alternating stretches of back-to-back traffic and gappy traffic.
    int unsigned send_calm_left = 0;
    bit          send_calm      = 1'b0;

    stepper_ramp_direction_control_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_now_us       (i_now_us),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_step_pulse   (o_step_pulse),
        .o_direction    (o_direction),
        .o_stopped_flag (o_stopped_flag),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Both monitors sample at the rising edge, so they see the same values the
    // block uses to complete a transaction. The request side feeds the predictor,
    // the result side is checked against the oldest queued expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            scoreboard.note_request(i_req_type, i_now_us);
            requests_taken <= requests_taken + 1;
        end
        if (i_rst_n && o_out_valid && i_out_ready)
            scoreboard.check_result(t_motion'({o_step_pulse, o_direction, o_stopped_flag}));
    end

    // Result receiver. It mixes calm stretches that take every result with
    // stretches of short and occasional long stalls. Once, after 150 requests, it
    // holds off while the sender keeps offering, so the result
    // register and then the input register fill and o_in_ready has to drop.
    initial begin
        int unsigned hold;
        int unsigned calm_left;
        int unsigned r;
        bit          calm;
        bit          long_hold_done;
        hold = 0;
        calm_left = 0;
        calm = 1'b0;
        long_hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold != 0) begin
                hold--;
            end else if (!long_hold_done && requests_taken >= 150) begin
                long_hold_done = 1'b1;
                i_out_ready <= 1'b0;
                hold = 80;
            end else begin
                if (calm_left == 0) begin
                    calm_left = $urandom_range(20, 60);
                    calm = ($urandom_range(0, 99) < 35);
                end
                calm_left--;
                r = $urandom_range(0, 99);
                if (calm || r < 70) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 30);
                end
            end
        end
    end

    // Gap after a request transaction: mostly none, sometimes a short one,
    // rarely a long pause.
    function automatic int unsigned sender_pause();
        int unsigned r;
        if (send_calm_left == 0) begin
            send_calm_left = $urandom_range(10, 40);
            send_calm = ($urandom_range(0, 99) < 30);
        end
        send_calm_left--;
        r = $urandom_range(0, 99);
        if (send_calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one request and returns at the edge where it is taken, or after the
    // gap that follows. With no gap, valid stays high for the next call.
    task automatic send_request(input logic [1:0] req, input logic [31:0] now_us);
        int unsigned pause;
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_now_us   <= now_us;
        do @(posedge i_clk); while (!o_in_ready);
        pause = sender_pause();
        if (pause != 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
    endtask

    // One configuration transaction; the predictor takes the value once the
    // block has accepted it.
    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        scoreboard.write_reg(index, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes the whole register set. Bits above a narrow register's width carry
    // random junk that the block must drop.
    task automatic configure(input logic [15:0] fast_limit, input logic [15:0] slow_limit,
                             input logic [7:0] delay_step, input logic fwd_level);
        write_reg(CFG_FAST_LIMIT, fast_limit);
        write_reg(CFG_SLOW_LIMIT, slow_limit);
        write_reg(CFG_DELAY_STEP, {8'($urandom), delay_step});
        write_reg(CFG_FWD_LEVEL, {15'($urandom), fwd_level});
    endtask

    // Stops offering requests and waits until every expected result is out,
    // then lets the two-stage pipeline drain.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (scoreboard.due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Moves the sender's time forward. Most steps land just past the current step
    // delay so the ramp actually moves; the rest fall short, repeat the same time,
    // jump far, or pick an arbitrary time anywhere in the 32-bit range.
    task automatic advance_clock();
        logic [31:0] span;
        int unsigned r;
        span = {16'd0, scoreboard.ramp.step_delay};
        r = $urandom_range(0, 99);
        if (r < 55)
            clock_us = clock_us + span + $urandom_range(0, 3);
        else if (r < 75)
            clock_us = clock_us + $urandom_range(0, span);
        else if (r < 83)
            clock_us = clock_us;
        else if (r < 93)
            clock_us = clock_us + $urandom_range(0, 200000);
        else
            clock_us = $urandom;
    endtask

    // Runs of requests in one heading, with occasional reversals so the ramp
    // slows to a halt and turns, sprinkled with stop and unused codes.
    task automatic random_items(input int unsigned count);
        logic [1:0]  req;
        logic [1:0]  heading;
        int unsigned r;
        heading = scoreboard.ahead_request();
        repeat (count) begin
            if ($urandom_range(0, 99) < 7)
                heading = (heading == REQ_FORWARD) ? REQ_BACKWARD : REQ_FORWARD;
            r = $urandom_range(0, 99);
            if (r < 4)
                req = REQ_STOP;
            else if (r < 6)
                req = REQ_UNUSED;
            else
                req = heading;
            advance_clock();
            send_request(req, clock_us);
        end
    endtask

    initial begin
        logic [1:0] heading;
        scoreboard = new;
        scoreboard.restart();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings except the forward level, flipped before any request so
        // that the stopped flag left over from reset lets the first request turn.
        write_reg(CFG_FWD_LEVEL, 16'h0000);
        send_request(REQ_UNUSED, 32'hFFFF_FFFF);
        send_request(REQ_STOP, 32'h0000_0000);
        send_request(REQ_FORWARD, 32'h0000_0000);
        send_request(REQ_FORWARD, 32'd5000);
        send_request(REQ_FORWARD, 32'd9989);
        send_request(REQ_FORWARD, 32'd9990);
        // Reverse: slow back up to the maximum, then stop, turn and step.
        send_request(REQ_BACKWARD, 32'd14970);
        send_request(REQ_BACKWARD, 32'd19960);
        send_request(REQ_BACKWARD, 32'd24960);
        send_request(REQ_STOP, 32'hAAAA_AAAA);
        send_request(REQ_BACKWARD, 32'h5555_5555);
        send_request(REQ_BACKWARD, 32'hFFFF_FFFF);
        // The time counter wraps between these two.
        send_request(REQ_BACKWARD, 32'h0000_1000);
        send_request(REQ_BACKWARD, 32'h0000_1400);
        send_request(REQ_UNUSED, 32'h0000_0000);
        clock_us = 32'h0000_1400;
        random_items(60);
        settle();

        // Short ramp so random runs reach top speed and full reversals.
        configure(16'd100, 16'd400, 8'd25, 1'b1);
        random_items(90);
        settle();

        // All registers at zero: every move request with elapsed time steps.
        configure(16'd0, 16'd0, 8'd0, 1'b0);
        random_items(50);
        settle();

        // All registers at their top values.
        configure(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        random_items(50);
        settle();

        // Shrink floors at zero below a zero minimum, then with a zero step a
        // reversal steps twice in the same request.
        configure(16'd0, 16'd10, 8'hFF, 1'b1);
        settle();
        heading = scoreboard.ahead_request();
        clock_us = scoreboard.ramp.last_time + 32'd100;
        send_request(REQ_STOP, clock_us);
        send_request(heading, clock_us);
        settle();
        configure(16'd0, 16'd10, 8'd0, 1'b1);
        send_request(scoreboard.reverse_request(), clock_us);
        random_items(40);
        settle();

        // Delay growth saturating at 65535: park the delay just below the
        // maximum, raise the maximum, then reverse.
        configure(16'd1000, 16'd65400, 8'hFF, 1'b1);
        send_request(REQ_STOP, clock_us);
        settle();
        configure(16'd1000, 16'hFFFF, 8'hFF, 1'b1);
        clock_us = scoreboard.ramp.last_time + 32'd70000;
        send_request(scoreboard.reverse_request(), clock_us);
        random_items(60);
        settle();

        // Back to the reset ramp with the regular forward level.
        configure(RST_FAST_LIMIT, RST_SLOW_LIMIT, RST_DELAY_STEP, RST_FWD_LEVEL);
        random_items(100);
        settle();

        if (scoreboard.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #(5_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
design/srdc_pkg.sv
design/srdc_cfg_regs.sv
design/srdc_ramp_core.sv
design/stepper_ramp_direction_control_top.sv
verif/tb_stepper_ramp_direction_control_top.sv
